/* hw/rtl/umf_pkg.sv */
// ----------------------------------------------------------------------------
// umf_pkg: shared types and constants of the unsharp mask filter.
// Widths of the register fields and the line store geometry.
// ----------------------------------------------------------------------------
`default_nettype none
package umf_pkg;
	localparam int MaxWidth   = 1024;
	localparam int StoreRows  = 4;
	localparam int ColW       = $clog2(MaxWidth);
	localparam int StoreDepth = StoreRows * MaxWidth;
	localparam int StoreAw    = $clog2(StoreDepth);

	localparam logic [2:0] RegWidth  = 3'd0;
	localparam logic [2:0] RegHeight = 3'd1;
	localparam logic [2:0] RegCenter = 3'd2;
	localparam logic [2:0] RegNear   = 3'd3;
	localparam logic [2:0] RegFar    = 3'd4;
	localparam logic [2:0] RegThresh = 3'd5;
	localparam logic [2:0] RegGain   = 3'd6;

	typedef struct packed {
		logic [10:0] frame_width;
		logic [11:0] frame_height;
		logic [16:0] coef_center;
		logic [15:0] coef_near;
		logic [15:0] coef_far;
		logic [11:0] detail_threshold;
		logic [11:0] detail_gain;
	} cfg_t;

	// One 5x5 window job for the enhancement datapath.
	typedef struct packed {
		logic [24:0][7:0] win;
		logic             row_end;
		logic             frame_end;
		logic             run_last;
	} job_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EMIT
	} seq_state_t;
endpackage
`default_nettype wire

/* hw/rtl/umf_ram.sv */
// ----------------------------------------------------------------------------
// umf_ram: generic simple dual-port synchronous RAM.
// One write and one read per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module umf_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* hw/rtl/umf_enhance.sv */
// ----------------------------------------------------------------------------
// umf_enhance: pipelined separable smoothing and detail enhancement.
// Takes one 5x5 window per cycle while not stalled and produces one output pixel.
// ----------------------------------------------------------------------------
`default_nettype none
module umf_enhance (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire umf_pkg::cfg_t cfg,
	input  wire logic          in_valid,
	input  wire umf_pkg::job_t in_job,
	input  wire logic          stall,
	output logic               out_valid,
	output logic [7:0]         out_pixel,
	output logic [2:0]         out_flags
);
	// Stage 1: column sums of pixel pairs.
	logic [4:0][7:0] cen_s1;
	logic [4:0][8:0] nsum_s1, fsum_s1;
	logic [7:0] px_s1;
	logic [2:0] fl_s1, fl_s2, fl_s3, fl_s4, fl_s5, fl_s6;
	logic [7:0] px_s2, px_s3, px_s4, px_s5, px_s6;
	logic v1, v2, v3, v4, v5, v6;
	// Stage 2: products of the vertical pass.
	logic [4:0][24:0] pc_s2, pn_s2, pf_s2;
	// Stage 3: vertical results (Q11.16), wide enough for any register value.
	logic [4:0][26:0] vert_s3;
	// Stage 4: horizontal pair sums.
	logic [26:0] hc_s4;
	logic [27:0] hn_s4, hf_s4;
	// Stage 5: horizontal products.
	logic [43:0] qc_s5;
	logic [43:0] qn_s5, qf_s5;
	// Stage 6: detail and threshold test.
	logic signed [46:0] d_s6;
	logic enh_s6;
	// Stage 7: gain product.
	logic signed [59:0] g_s7;
	logic [7:0] px_s7;
	logic [2:0] fl_s7;
	logic enh_s7, v7;

	logic [45:0] hsum;
	logic signed [46:0] dval;
	logic [46:0] adval;
	logic signed [59:0] vsum;

	assign hsum = 46'(qc_s5) + 46'(qn_s5) + 46'(qf_s5);
	assign dval = $signed(47'({px_s5, 32'b0})) - $signed({1'b0, hsum});
	assign adval = dval[46] ? 47'(-dval) : 47'(dval);
	assign vsum = $signed(60'({px_s7, 40'b0})) + g_s7 + 60'sd549755813888;

	// Valid pipeline, held while the output is stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v1, v2, v3, v4, v5, v6, v7, out_valid} <= '0;
		end else if (!stall) begin
			{v1, v2, v3, v4, v5, v6, v7, out_valid} <=
				{in_valid, v1, v2, v3, v4, v5, v6, v7};
		end
	end

	// Datapath stages.
	always_ff @(posedge clk) begin
		if (!stall) begin
			for (int c = 0; c < 5; c++) begin
				cen_s1[c]  <= in_job.win[c*5+2];
				nsum_s1[c] <= 9'(in_job.win[c*5+1]) + 9'(in_job.win[c*5+3]);
				fsum_s1[c] <= 9'(in_job.win[c*5+0]) + 9'(in_job.win[c*5+4]);
			end
			px_s1 <= in_job.win[12];
			fl_s1 <= {in_job.frame_end, in_job.row_end, in_job.run_last};
			for (int c = 0; c < 5; c++) begin
				pc_s2[c] <= 25'(cfg.coef_center * cen_s1[c]);
				pn_s2[c] <= 25'(cfg.coef_near * nsum_s1[c]);
				pf_s2[c] <= 25'(cfg.coef_far * fsum_s1[c]);
				vert_s3[c] <= 27'(pc_s2[c]) + 27'(pn_s2[c]) + 27'(pf_s2[c]);
			end
			hc_s4 <= vert_s3[2];
			hn_s4 <= 28'(vert_s3[1]) + 28'(vert_s3[3]);
			hf_s4 <= 28'(vert_s3[0]) + 28'(vert_s3[4]);
			qc_s5 <= 44'(cfg.coef_center * hc_s4);
			qn_s5 <= 44'(cfg.coef_near * hn_s4);
			qf_s5 <= 44'(cfg.coef_far * hf_s4);
			d_s6 <= dval;
			enh_s6 <= adval > {7'b0, cfg.detail_threshold, 28'b0};
			g_s7 <= $signed({1'b0, cfg.detail_gain}) * d_s6;
			{px_s2, px_s3, px_s4, px_s5, px_s6, px_s7} <=
				{px_s1, px_s2, px_s3, px_s4, px_s5, px_s6};
			{fl_s2, fl_s3, fl_s4, fl_s5, fl_s6, fl_s7} <=
				{fl_s1, fl_s2, fl_s3, fl_s4, fl_s5, fl_s6};
			enh_s7 <= enh_s6;
			out_flags <= fl_s7;
			if (!enh_s7) begin
				out_pixel <= px_s7;
			end else if (vsum[59]) begin
				out_pixel <= 8'd0;
			end else if (vsum[58:40] > 19'd255) begin
				out_pixel <= 8'd255;
			end else begin
				out_pixel <= vsum[47:40];
			end
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/umf_window.sv */
// ----------------------------------------------------------------------------
// umf_window: line store, raw window and result sequencer.
// Keeps the last four rows in one line RAM, one byte lane per row slot, read
// and written back once per pixel; builds the 5x5 window and issues zero to
// nine windows per input pixel.
// ----------------------------------------------------------------------------
`default_nettype none
module umf_window (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire umf_pkg::cfg_t cfg,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    in_pixel,
	input  wire logic          stall,
	output logic               job_valid,
	output umf_pkg::job_t      job,
	output logic               busy
);
	localparam int CW = umf_pkg::ColW;

	umf_pkg::seq_state_t state_q, state_d;
	logic [CW-1:0] col_q;
	logic [11:0]   row_q;
	logic [4:0][4:0][7:0] win_q; // [column age][row]
	logic [1:0][4:0][7:0] keep_q; // two oldest columns of the saved window
	logic [4:0][7:0] edge_q;
	logic [1:0] pass_q, passes_q, s_q, rows_q;
	logic row_end_q, last_row_q, rd_pend_q;
	logic [7:0] px_q;
	logic [3:0][7:0] rdata, wword;
	logic [CW:0] effw;
	logic [11:0] effh;
	logic acc, is_row_end, is_last_row;

	// Effective geometry.
	always_comb begin
		if (cfg.frame_width < 11'd5) begin
			effw = (CW+1)'(5);
		end else if ({1'b0, cfg.frame_width} > 12'(umf_pkg::MaxWidth)) begin
			effw = (CW+1)'(umf_pkg::MaxWidth);
		end else begin
			effw = (CW+1)'(cfg.frame_width);
		end
		effh = (cfg.frame_height < 12'd5) ? 12'd5 : cfg.frame_height;
	end

	assign in_ready = (state_q == umf_pkg::ST_IDLE) && !rd_pend_q;
	assign acc = in_valid && in_ready;
	assign busy = (state_q != umf_pkg::ST_IDLE) || rd_pend_q;
	assign is_row_end = {1'b0, col_q} >= effw - 1'b1;
	assign is_last_row = row_q >= effh - 12'd1;

	// The new pixel replaces the lane of its row slot in the word just read.
	always_comb begin
		wword = rdata;
		wword[row_q[1:0]] = px_q;
	end

	// One line RAM word per column holds the four stored rows.
	umf_ram #(.Width(32), .Depth(umf_pkg::MaxWidth)) u_ram (
		.clk  (clk),
		.we   (rd_pend_q),
		.waddr(col_q),
		.wdata(wword),
		.raddr(col_q),
		.rdata(rdata)
	);

	// Column of five rows for the current pixel, oldest first.
	logic [4:0][7:0] vcol;
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			if ({2'b0, row_q} + 14'(k) < 14'd4) begin
				vcol[k] = (row_q == 12'd0) ? px_q : rdata[2'(0)];
			end else begin
				vcol[k] = rdata[2'(row_q - 12'd4 + 12'(k))];
			end
			if (row_q < 12'd4 && (12'(k) + row_q >= 12'd4) == 1'b0) begin
				vcol[k] = (row_q == 12'd0) ? px_q : rdata[2'd0];
			end
		end
		vcol[4] = px_q;
	end

	// Window for the current output, with bottom-row replication.
	always_comb begin
		for (int c = 0; c < 5; c++) begin
			for (int k = 0; k < 5; k++) begin
				job.win[c*5+k] = win_q[c][(k + s_q > 4) ? 4 : k + s_q];
			end
		end
		job.row_end   = row_end_q && (pass_q == passes_q);
		job.frame_end = job.row_end && last_row_q && (s_q == rows_q);
		job.run_last  = (pass_q == passes_q) && (s_q == rows_q);
	end
	assign job_valid = (state_q == umf_pkg::ST_EMIT);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			umf_pkg::ST_IDLE: begin
				if (rd_pend_q && row_q >= 12'd2 && col_q >= CW'(2)) begin
					state_d = umf_pkg::ST_EMIT;
				end
			end
			umf_pkg::ST_EMIT: begin
				if (!stall && pass_q == passes_q && s_q == rows_q) begin
					state_d = umf_pkg::ST_IDLE;
				end
			end
			default: state_d = umf_pkg::ST_IDLE;
		endcase
	end

	// Control and window registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= umf_pkg::ST_IDLE;
			col_q <= '0;
			row_q <= '0;
			rd_pend_q <= 1'b0;
			pass_q <= '0;
			s_q <= '0;
		end else begin
			state_q <= state_d;
			rd_pend_q <= acc;
			if (rd_pend_q) begin
				pass_q <= '0;
				s_q <= '0;
			end else if (state_q == umf_pkg::ST_EMIT && !stall) begin
				if (pass_q != passes_q) begin
					pass_q <= pass_q + 2'd1;
				end else begin
					pass_q <= '0;
					s_q <= s_q + 2'd1;
				end
			end
			// Advance position once the current pixel is written back and its windows are all issued.
			if (rd_pend_q && state_d == umf_pkg::ST_IDLE) begin
				if (is_row_end) begin
					col_q <= '0;
					row_q <= is_last_row ? 12'd0 : row_q + 12'd1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end else if (state_q == umf_pkg::ST_EMIT && state_d == umf_pkg::ST_IDLE) begin
				if (row_end_q) begin
					col_q <= '0;
					row_q <= last_row_q ? 12'd0 : row_q + 12'd1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			px_q <= in_pixel;
		end
		if (rd_pend_q) begin
			edge_q <= vcol;
			row_end_q <= is_row_end;
			last_row_q <= is_last_row;
			passes_q <= is_row_end ? 2'd2 : 2'd0;
			rows_q <= is_last_row ? 2'd2 : 2'd0;
			if (col_q == '0) begin
				for (int c = 0; c < 5; c++) win_q[c] <= vcol;
				keep_q[0] <= vcol;
				keep_q[1] <= vcol;
			end else begin
				win_q[3:0] <= win_q[4:1];
				win_q[4] <= vcol;
				keep_q[0] <= win_q[1];
				keep_q[1] <= win_q[2];
			end
		end else if (state_q == umf_pkg::ST_EMIT && !stall) begin
			// Flush passes shift in the edge column; restore between rows.
			if (pass_q != passes_q) begin
				win_q[3:0] <= win_q[4:1];
				win_q[4] <= edge_q;
			end else if (passes_q != 2'd0) begin
				win_q[0] <= keep_q[0];
				win_q[1] <= keep_q[1];
				win_q[2] <= win_q[0];
				win_q[3] <= win_q[1];
				win_q[4] <= edge_q;
			end
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/unsharp_mask_filter.sv */
// ----------------------------------------------------------------------------
// unsharp_mask_filter: 5x5 separable unsharp mask on a raster pixel stream.
// ----------------------------------------------------------------------------
// A pixel is taken only while the sequencer is idle: the accepting cycle
// reads the word of its column from the line RAM, the next cycle builds the
// window and writes the pixel back, and then the sequencer issues in turn
// the zero to nine results the pixel releases (three at a row end, three
// rows in the last input row, nine at the frame end) before it takes the
// next pixel. A stalled output holds the sequencer. Results leave an
// eight-stage enhancement pipeline.
`default_nettype none
module unsharp_mask_filter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // pixel_in
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,  // pixel_out
	output logic [1:0]       m_tuser,  // frame_end, row_end
	output logic             m_tlast   // run_last
);
	umf_pkg::cfg_t cfg_q;
	umf_pkg::job_t job;
	logic job_valid, busy, stall, pvalid;
	logic [7:0] ppix;
	logic [2:0] pfl;
	logic wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{11'd1024, 12'd480, 17'd65536, 16'd0, 16'd0, 12'd0, 12'd256};
		end else if (wr) begin
			unique case (paddr[4:2])
				umf_pkg::RegWidth:  cfg_q.frame_width <= pwdata[10:0];
				umf_pkg::RegHeight: cfg_q.frame_height <= pwdata[11:0];
				umf_pkg::RegCenter: cfg_q.coef_center <= pwdata[16:0];
				umf_pkg::RegNear:   cfg_q.coef_near <= pwdata[15:0];
				umf_pkg::RegFar:    cfg_q.coef_far <= pwdata[15:0];
				umf_pkg::RegThresh: cfg_q.detail_threshold <= pwdata[11:0];
				umf_pkg::RegGain:   cfg_q.detail_gain <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	// Register reads.
	always_comb begin
		unique case (paddr[4:2])
			umf_pkg::RegWidth:  prdata = 32'(cfg_q.frame_width);
			umf_pkg::RegHeight: prdata = 32'(cfg_q.frame_height);
			umf_pkg::RegCenter: prdata = 32'(cfg_q.coef_center);
			umf_pkg::RegNear:   prdata = 32'(cfg_q.coef_near);
			umf_pkg::RegFar:    prdata = 32'(cfg_q.coef_far);
			umf_pkg::RegThresh: prdata = 32'(cfg_q.detail_threshold);
			umf_pkg::RegGain:   prdata = 32'(cfg_q.detail_gain);
			default:            prdata = 32'd0;
		endcase
	end

	assign stall = pvalid && !m_tready;

	umf_window u_window (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.in_valid(s_tvalid), .in_ready(s_tready), .in_pixel(s_tdata),
		.stall(stall), .job_valid(job_valid), .job(job), .busy(busy)
	);

	umf_enhance u_enhance (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.in_valid(job_valid), .in_job(job), .stall(stall),
		.out_valid(pvalid), .out_pixel(ppix), .out_flags(pfl)
	);

	assign m_tvalid = pvalid;
	assign m_tdata  = ppix;
	assign m_tuser  = {pfl[2], pfl[1]};
	assign m_tlast  = pfl[0] && !busy ? pfl[0] : pfl[0];
endmodule
`default_nettype wire

/* hw/rtl/umf_checker.sv */
// ----------------------------------------------------------------------------
// umf_checker: port-level checks of the unsharp mask filter.
// ----------------------------------------------------------------------------
`default_nettype none
module umf_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic [1:0] m_tuser,
	input wire logic       m_tlast,
	input wire logic       pready
);
	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed under stall");
	// A frame end is also a row end.
	a_fe: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tuser[0])
		else $error("frame end without row end");
	// A frame end closes the run of its input.
	a_fl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast)
		else $error("frame end not last of run");
	a_rdy: assert property (@(posedge clk) pready)
		else $error("pready low");
endmodule

bind unsharp_mask_filter umf_checker u_checker (
	.clk(clk), .arst_n(arst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
	.m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast), .pready(pready)
);
`default_nettype wire
